FILE: rtl/core/bpmc_pkg.sv
`default_nettype none

package bpmc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED_TO_EXT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_TO_CLOSED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALMOST_TO_OPN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OPN_TO_ALMOST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALMOST_TO_EXT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_TO_ALMOST = 3'd7;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [2:0] M_OFF       = 3'd0;
    localparam logic [2:0] M_UP_SLOW   = 3'd1;
    localparam logic [2:0] M_DOWN_SLOW = 3'd2;
    localparam logic [2:0] M_UP_FAST   = 3'd3;
    localparam logic [2:0] M_DOWN_FAST = 3'd4;

    localparam logic [2:0] P_UNKNOWN  = 3'd0;
    localparam logic [2:0] P_CLOSED   = 3'd1;
    localparam logic [2:0] P_EXTENDED = 3'd2;
    localparam logic [2:0] P_MIDDLE   = 3'd3;
    localparam logic [2:0] P_ALMOST   = 3'd4;
    localparam logic [2:0] P_OPEN     = 3'd5;

    // pin bits: 0 up, 1 down, 2 fast, 3 enable_n
    localparam logic [3:0] PINS_OFF       = 4'b1000;
    localparam logic [3:0] PINS_UP_SLOW   = 4'b0001;
    localparam logic [3:0] PINS_DOWN_SLOW = 4'b0010;
    localparam logic [3:0] PINS_UP_FAST   = 4'b0101;
    localparam logic [3:0] PINS_DOWN_FAST = 4'b0110;

    typedef struct packed {
        logic [7:0]  debounce;
        logic [9:0]  dead_time;
        logic [15:0] closed_to_ext;
        logic [15:0] ext_to_closed;
        logic [15:0] almost_to_open;
        logic [15:0] open_to_almost;
        logic [15:0] almost_to_ext;
        logic [15:0] ext_to_almost;
    } bpmc_cfg_t;

    typedef struct packed {
        logic        primed;
        logic        bot_stable;
        logic        bot_last;
        logic [7:0]  bot_wait;
        logic        bot_ready;
        logic [2:0]  mode;
        logic [15:0] run_left;
        logic        run_armed;
        logic [9:0]  dead_left;
        logic        dead_armed;
        logic [2:0]  pos;
        logic [2:0]  goal;
        logic        homed;
        logic [3:0]  pins;
    } bpmc_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/bpmc_cfg.sv
`default_nettype none

module bpmc_cfg
    import bpmc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output bpmc_cfg_t                  cfg
);

    bpmc_cfg_t cfg_reg;
    bpmc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEBOUNCE:      cfg_next.debounce       = cfg_data[7:0];
                REG_DEAD_TIME:     cfg_next.dead_time      = cfg_data[9:0];
                REG_CLOSED_TO_EXT: cfg_next.closed_to_ext  = cfg_data;
                REG_EXT_TO_CLOSED: cfg_next.ext_to_closed  = cfg_data;
                REG_ALMOST_TO_OPN: cfg_next.almost_to_open = cfg_data;
                REG_OPN_TO_ALMOST: cfg_next.open_to_almost = cfg_data;
                REG_ALMOST_TO_EXT: cfg_next.almost_to_ext  = cfg_data;
                REG_EXT_TO_ALMOST: cfg_next.ext_to_almost  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce       <= 8'd10;
            cfg_reg.dead_time      <= 10'd100;
            cfg_reg.closed_to_ext  <= 16'd3000;
            cfg_reg.ext_to_closed  <= 16'd3100;
            cfg_reg.almost_to_open <= 16'd4000;
            cfg_reg.open_to_almost <= 16'd1000;
            cfg_reg.almost_to_ext  <= 16'd10000;
            cfg_reg.ext_to_almost  <= 16'd4500;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bpmc_step.sv
`default_nettype none

module bpmc_step
    import bpmc_pkg::*;
(
    input  wire bpmc_cfg_t   cfg,
    input  wire bpmc_state_t state_cur,
    input  wire logic [1:0] cmd,
    input  wire logic   top,
    input  wire logic   bot,
    output bpmc_state_t state_nxt
);

    function automatic bpmc_state_t apply_mode(bpmc_state_t s_in, logic [2:0] m);
        bpmc_state_t s;
        s = s_in;
        s.mode = m;
        case (m)
            M_UP_FAST:   s.pins = PINS_UP_FAST;
            M_UP_SLOW:   s.pins = PINS_UP_SLOW;
            M_DOWN_FAST: s.pins = PINS_DOWN_FAST;
            M_DOWN_SLOW: s.pins = PINS_DOWN_SLOW;
            default:     s.pins = PINS_OFF;
        endcase
        return s;
    endfunction

    function automatic bpmc_state_t motor_set(bpmc_state_t s_in, logic [2:0] m,
                                              logic [15:0] limit, logic [9:0] dead);
        bpmc_state_t s;
        logic [2:0]  prev;
        s = s_in;
        prev = s.mode;
        s.mode = m;
        if (m == M_OFF)
        begin
            s = apply_mode(s, M_OFF);
        end
        else if (limit != 16'd0)
        begin
            s.run_left  = limit;
            s.run_armed = 1'b1;
        end
        else
        begin
            s.run_armed = 1'b0;
        end
        if (prev == m)
        begin
            s = apply_mode(s, m);
        end
        else
        begin
            s = apply_mode(s, M_OFF);
            s.mode       = m;
            s.dead_left  = dead;
            s.dead_armed = 1'b1;
        end
        return s;
    endfunction

    // debounced bottom edge: level held since last raw change and differs
    function automatic logic sense_hit(bpmc_state_t s, logic level);
        return (level == s.bot_last) && s.bot_ready && (level != s.bot_stable);
    endfunction

    function automatic bpmc_state_t sense_upd(bpmc_state_t s_in, logic level,
                                              logic [7:0] deb);
        bpmc_state_t s;
        s = s_in;
        if (level != s.bot_last)
        begin
            s.bot_wait  = deb;
            s.bot_ready = 1'b0;
        end
        else if (s.bot_ready && (level != s.bot_stable))
        begin
            s.bot_stable = level;
        end
        s.bot_last = level;
        return s;
    endfunction

    always_comb
    begin
        bpmc_state_t s;
        logic        hit;
        logic [2:0]  m;

        s   = state_cur;
        hit = 1'b0;
        m   = M_OFF;

        if (!s.primed)
        begin
            s.bot_stable = bot;
            s.bot_last   = bot;
            s.primed     = 1'b1;
        end
        if (s.run_left != 16'd0)
            s.run_left = s.run_left - 16'd1;
        if (s.dead_left != 10'd0)
            s.dead_left = s.dead_left - 10'd1;
        if (s.bot_wait != 8'd0)
            s.bot_wait = s.bot_wait - 8'd1;
        else
            s.bot_ready = 1'b1;

        // command
        if (cmd == CMD_STOP)
        begin
            s = motor_set(s, M_OFF, 16'd0, cfg.dead_time);
            s.goal = s.pos;
        end
        else if (cmd != CMD_NONE && s.homed)
        begin
            if (cmd == CMD_OPEN)
            begin
                if (s.pos != P_OPEN)
                begin
                    s.goal = P_OPEN;
                    if (s.pos == P_ALMOST)
                        s = motor_set(s, M_UP_SLOW, cfg.almost_to_open, cfg.dead_time);
                    else if (s.pos == P_CLOSED)
                        s = motor_set(s, M_UP_FAST, cfg.closed_to_ext, cfg.dead_time);
                    else
                        s = motor_set(s, M_UP_FAST, cfg.ext_to_almost, cfg.dead_time);
                end
            end
            else if (s.pos != P_CLOSED)
            begin
                s.goal       = P_CLOSED;
                s.bot_stable = bot;
                s.bot_last   = bot;
                if (bot)
                begin
                    s = motor_set(s, M_DOWN_SLOW, cfg.ext_to_closed, cfg.dead_time);
                end
                else if (s.pos == P_OPEN)
                begin
                    s.pos = P_ALMOST;
                    s = motor_set(s, M_DOWN_SLOW, cfg.open_to_almost, cfg.dead_time);
                end
                else
                begin
                    s = motor_set(s, M_DOWN_SLOW, cfg.almost_to_ext, cfg.dead_time);
                end
            end
        end

        // run timeout and dead time
        if (s.run_armed && s.run_left == 16'd0)
        begin
            s = apply_mode(s, M_OFF);
            s.run_armed = 1'b0;
        end
        else if (s.dead_armed && s.dead_left == 10'd0)
        begin
            s = apply_mode(s, s.mode);
            s.dead_armed = 1'b0;
        end

        if (!s.homed)
        begin
            if (s.pos == P_UNKNOWN)
            begin
                if (top)
                begin
                    s.pos   = P_OPEN;
                    s.homed = 1'b1;
                    s.goal  = P_OPEN;
                end
                else
                begin
                    s.bot_stable = bot;
                    s.bot_last   = bot;
                    if (bot)
                    begin
                        s.pos = P_EXTENDED;
                        s = motor_set(s, M_UP_FAST, cfg.closed_to_ext, cfg.dead_time);
                    end
                    else
                    begin
                        s.pos = P_MIDDLE;
                        s = motor_set(s, M_DOWN_SLOW, cfg.almost_to_ext, cfg.dead_time);
                    end
                end
            end
            else
            begin
                case (s.mode)
                    M_UP_FAST:
                    begin
                        hit = sense_hit(s, bot);
                        s = sense_upd(s, bot, cfg.debounce);
                        if (hit && !s.bot_stable)
                            s = motor_set(s, M_DOWN_SLOW, cfg.ext_to_closed, cfg.dead_time);
                        if (top)
                            s = motor_set(s, M_OFF, 16'd0, cfg.dead_time);
                    end
                    M_DOWN_SLOW:
                    begin
                        hit = sense_hit(s, bot);
                        s = sense_upd(s, bot, cfg.debounce);
                        if (hit && bot)
                            s = motor_set(s, M_DOWN_SLOW, cfg.ext_to_closed, cfg.dead_time);
                    end
                    M_OFF:
                    begin
                        s.pos   = P_CLOSED;
                        s.homed = 1'b1;
                        s.goal  = P_CLOSED;
                    end
                    default:
                    begin
                        s.homed = s.homed;
                    end
                endcase
            end
        end
        else if (s.pos != s.goal)
        begin
            m = s.mode;
            if (m == M_UP_FAST || m == M_UP_SLOW)
            begin
                hit = sense_hit(s, bot);
                s = sense_upd(s, bot, cfg.debounce);
                if (hit && !s.bot_stable)
                begin
                    s.pos = P_MIDDLE;
                    s = motor_set(s, M_UP_FAST, cfg.ext_to_almost, cfg.dead_time);
                end
                else if (top)
                begin
                    s.pos = P_OPEN;
                    s = motor_set(s, M_OFF, 16'd0, cfg.dead_time);
                end
            end
            else
            begin
                if (m == M_OFF)
                begin
                    if (s.pos == P_EXTENDED && s.goal == P_CLOSED)
                    begin
                        s.pos = P_CLOSED;
                    end
                    else if (s.pos == P_MIDDLE && s.goal == P_OPEN)
                    begin
                        s.pos = P_ALMOST;
                        s = motor_set(s, M_UP_SLOW, cfg.almost_to_open, cfg.dead_time);
                    end
                    else if (s.pos == P_ALMOST && s.goal == P_CLOSED)
                    begin
                        s.pos = P_MIDDLE;
                        s = motor_set(s, M_DOWN_SLOW, cfg.almost_to_ext, cfg.dead_time);
                    end
                end
                // off falls through into the downward check
                if (m == M_OFF || m == M_DOWN_SLOW || m == M_DOWN_FAST)
                begin
                    hit = sense_hit(s, bot);
                    s = sense_upd(s, bot, cfg.debounce);
                    if (hit && s.bot_stable)
                    begin
                        s.pos = P_EXTENDED;
                        s = motor_set(s, M_DOWN_SLOW, cfg.ext_to_closed, cfg.dead_time);
                    end
                end
            end
        end

        state_nxt = s;
    end

endmodule

`default_nettype wire

FILE: rtl/core/blind_position_motor_controller.sv
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_stall  | cmd, top_active, bottom_active
// out      | out_valid / out_stall| drive_up, drive_down, drive_fast, enable_n,
//          |                      | position, motor_mode, homed
// cfg      | cfg_wr_en            | cfg_index, cfg_data
//
// One beat per clock sustained while out is not stalled.
// Input register, then one pass of tick logic into the state register, which is
// also the output register.
// in_stall rises only when the input register holds a beat and out is stalled.
// Reset: motor off, enable_n high, position unknown, registers at defaults.

module blind_position_motor_controller
    import bpmc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            cmd,
    input  wire logic                  top_active,
    input  wire logic                  bottom_active,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       drive_up,
    output logic                       drive_down,
    output logic                       drive_fast,
    output logic                       enable_n,
    output logic [2:0]                 position,
    output logic [2:0]                 motor_mode,
    output logic                       homed,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    bpmc_cfg_t   cfg;
    bpmc_state_t state_reg;
    bpmc_state_t state_next;

    logic       in_valid_reg;
    logic [1:0] cmd_reg;
    logic       top_reg;
    logic       bot_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       in_take;
    logic       advance;

    bpmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpmc_step u_step (
        .cfg       (cfg),
        .state_cur (state_reg),
        .cmd       (cmd_reg),
        .top       (top_reg),
        .bot       (bot_reg),
        .state_nxt (state_next)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{bot_ready: 1'b1, mode: M_OFF, pos: P_UNKNOWN,
                               goal: P_UNKNOWN, pins: PINS_OFF, default: '0};
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (out_free)
                in_valid_reg <= 1'b0;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= cmd;
            top_reg <= top_active;
            bot_reg <= bottom_active;
        end
    end

    assign out_valid  = out_valid_reg;
    assign drive_up   = state_reg.pins[0];
    assign drive_down = state_reg.pins[1];
    assign drive_fast = state_reg.pins[2];
    assign enable_n   = state_reg.pins[3];
    assign position   = state_reg.pos;
    assign motor_mode = state_reg.mode;
    assign homed      = state_reg.homed;

endmodule

`default_nettype wire

FILE: tb/sv/tb_blind_position_motor_controller.sv
`timescale 1ns / 100ps

module tb_blind_position_motor_controller;
    import bpmc_pkg::*;

    typedef struct packed {
        logic       up;
        logic       down;
        logic       fast;
        logic       en_n;
        logic [2:0] pos;
        logic [2:0] mode;
        logic       homed;
    } motor_report_t;

    typedef struct {
        bit                    wr;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [1:0]            c;
        logic                  t;
        logic                  b;
        bit                    fixed;
        motor_report_t         rpt;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            cmd;
    logic                  top_active;
    logic                  bottom_active;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  drive_up;
    logic                  drive_down;
    logic                  drive_fast;
    logic                  enable_n;
    logic [2:0]            position;
    logic [2:0]            motor_mode;
    logic                  homed;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // controller image
    bpmc_cfg_t   cfg_now;
    bit          primed;
    logic        bot_lvl;
    logic        bot_seen;
    logic [7:0]  bot_hold;
    logic        bot_rdy;
    logic [2:0]  mode_cur;
    logic [15:0] run_cnt;
    logic        run_on;
    logic [9:0]  dead_cnt;
    logic        dead_on;
    logic [2:0]  pos_cur;
    logic [2:0]  pos_want;
    logic        homed_f;
    logic [3:0]  pins;

    motor_report_t motor_reports[$];
    motor_report_t want_rpt;
    plan_row_t     plan[$];

    int   n_fail = 0;
    int   n_seen = 0;
    int   n_ticks = 0;
    int   burst_left = 0;
    bit   wr_open = 1'b0;
    logic sens_top = 1'b0;
    logic sens_bot = 1'b0;
    logic [7:0] pos_mask = '0;
    logic [7:0] mode_mask = '0;

    int         hold_left = 0;
    bit         held = 1'b0;
    int         rx_beats = 0;
    logic [7:0] stall_phase = 8'd0;
    int         stall_style = 0;

    blind_position_motor_controller u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .top_active    (top_active),
        .bottom_active (bottom_active),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive_up      (drive_up),
        .drive_down    (drive_down),
        .drive_fast    (drive_fast),
        .enable_n      (enable_n),
        .position      (position),
        .motor_mode    (motor_mode),
        .homed         (homed),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void set_pins(logic [2:0] m);
        mode_cur = m;
        case (m)
            M_UP_FAST:   pins = PINS_UP_FAST;
            M_UP_SLOW:   pins = PINS_UP_SLOW;
            M_DOWN_FAST: pins = PINS_DOWN_FAST;
            M_DOWN_SLOW: pins = PINS_DOWN_SLOW;
            default:     pins = PINS_OFF;
        endcase
    endfunction

    function automatic void drive_motor(logic [2:0] m, logic [15:0] lim);
        logic [2:0] prev;
        prev = mode_cur;
        mode_cur = m;
        if (m == M_OFF)
            set_pins(M_OFF);
        else if (lim != 16'd0)
        begin
            run_cnt = lim;
            run_on = 1'b1;
        end
        else
            run_on = 1'b0;
        if (prev == m)
            set_pins(m);
        else
        begin
            set_pins(M_OFF);
            mode_cur = m;
            dead_cnt = cfg_now.dead_time;
            dead_on = 1'b1;
        end
    endfunction

    // debounced bottom change; the last level is not updated on a taken change
    function automatic bit bot_edge(logic lvl);
        if (lvl != bot_seen)
        begin
            bot_hold = cfg_now.debounce;
            bot_rdy = 1'b0;
        end
        if (lvl != bot_lvl && bot_rdy)
        begin
            bot_lvl = lvl;
            return 1'b1;
        end
        bot_seen = lvl;
        return 1'b0;
    endfunction

    function automatic logic bot_now(logic lvl);
        bot_lvl = lvl;
        bot_seen = lvl;
        return lvl;
    endfunction

    function automatic void home_step(logic t, logic b);
        bit hit;
        if (pos_cur == P_UNKNOWN)
        begin
            if (t)
            begin
                pos_cur = P_OPEN;
                homed_f = 1'b1;
                pos_want = pos_cur;
            end
            else if (bot_now(b))
            begin
                pos_cur = P_EXTENDED;
                drive_motor(M_UP_FAST, cfg_now.closed_to_ext);
            end
            else
            begin
                pos_cur = P_MIDDLE;
                drive_motor(M_DOWN_SLOW, cfg_now.almost_to_ext);
            end
            return;
        end
        case (mode_cur)
            M_UP_FAST:
            begin
                hit = bot_edge(b);
                if (hit && !bot_lvl)
                    drive_motor(M_DOWN_SLOW, cfg_now.ext_to_closed);
                if (t)
                    drive_motor(M_OFF, 16'd0);
            end
            M_DOWN_SLOW:
            begin
                hit = bot_edge(b);
                if (hit)
                    hit = bot_now(b);
                if (hit)
                    drive_motor(M_DOWN_SLOW, cfg_now.ext_to_closed);
            end
            M_OFF:
            begin
                pos_cur = P_CLOSED;
                homed_f = 1'b1;
                pos_want = pos_cur;
            end
            default: ;
        endcase
    endfunction

    function automatic void seq_step(logic t, logic b);
        logic [2:0] m;
        bit         hit;
        m = mode_cur;
        if (m == M_UP_FAST || m == M_UP_SLOW)
        begin
            hit = bot_edge(b);
            if (hit)
                hit = !bot_lvl;
            if (hit)
            begin
                pos_cur = P_MIDDLE;
                drive_motor(M_UP_FAST, cfg_now.ext_to_almost);
            end
            else if (t)
            begin
                pos_cur = P_OPEN;
                drive_motor(M_OFF, 16'd0);
            end
            return;
        end
        if (m == M_OFF)
        begin
            if (pos_cur == P_EXTENDED && pos_want == P_CLOSED)
                pos_cur = P_CLOSED;
            else if (pos_cur == P_MIDDLE && pos_want == P_OPEN)
            begin
                pos_cur = P_ALMOST;
                drive_motor(M_UP_SLOW, cfg_now.almost_to_open);
            end
            else if (pos_cur == P_ALMOST && pos_want == P_CLOSED)
            begin
                pos_cur = P_MIDDLE;
                drive_motor(M_DOWN_SLOW, cfg_now.almost_to_ext);
            end
        end
        // off falls through into the downward check
        if (m == M_OFF || m == M_DOWN_SLOW || m == M_DOWN_FAST)
        begin
            hit = bot_edge(b);
            if (hit)
                hit = bot_lvl;
            if (hit)
            begin
                pos_cur = P_EXTENDED;
                drive_motor(M_DOWN_SLOW, cfg_now.ext_to_closed);
            end
        end
    endfunction

    function automatic void apply_cmd(logic [1:0] c, logic b);
        if (c == CMD_STOP)
        begin
            drive_motor(M_OFF, 16'd0);
            pos_want = pos_cur;
            return;
        end
        if (c == CMD_NONE || !homed_f)
            return;
        if (c == CMD_OPEN)
        begin
            if (pos_cur == P_OPEN)
                return;
            pos_want = P_OPEN;
            if (pos_cur == P_ALMOST)
                drive_motor(M_UP_SLOW, cfg_now.almost_to_open);
            else if (pos_cur == P_CLOSED)
                drive_motor(M_UP_FAST, cfg_now.closed_to_ext);
            else
                drive_motor(M_UP_FAST, cfg_now.ext_to_almost);
        end
        else
        begin
            if (pos_cur == P_CLOSED)
                return;
            pos_want = P_CLOSED;
            if (bot_now(b))
                drive_motor(M_DOWN_SLOW, cfg_now.ext_to_closed);
            else if (pos_cur == P_OPEN)
            begin
                pos_cur = P_ALMOST;
                drive_motor(M_DOWN_SLOW, cfg_now.open_to_almost);
            end
            else
                drive_motor(M_DOWN_SLOW, cfg_now.almost_to_ext);
        end
    endfunction

    function automatic motor_report_t controller_tick(logic [1:0] c, logic t, logic b);
        motor_report_t r;
        if (!primed)
        begin
            bot_lvl = b;
            bot_seen = b;
            primed = 1'b1;
        end
        if (run_cnt > 16'd0)
            run_cnt--;
        if (dead_cnt > 10'd0)
            dead_cnt--;
        if (bot_hold > 8'd0)
            bot_hold--;
        else
            bot_rdy = 1'b1;
        apply_cmd(c, b);
        if (run_on && run_cnt == 16'd0)
        begin
            set_pins(M_OFF);
            run_on = 1'b0;
        end
        else if (dead_on && dead_cnt == 10'd0)
        begin
            set_pins(mode_cur);
            dead_on = 1'b0;
        end
        if (!homed_f)
            home_step(t, b);
        else if (pos_cur != pos_want)
            seq_step(t, b);
        r.up = pins[0];
        r.down = pins[1];
        r.fast = pins[2];
        r.en_n = pins[3];
        r.pos = pos_cur;
        r.mode = mode_cur;
        r.homed = homed_f;
        return r;
    endfunction

    function automatic plan_row_t beat_row(logic [1:0] c, logic t, logic b);
        plan_row_t r;
        r = '{default: '0};
        r.c = c;
        r.t = t;
        r.b = b;
        return r;
    endfunction

    function automatic plan_row_t known_row(logic [1:0] c, logic t, logic b,
                                            motor_report_t rpt);
        plan_row_t r;
        r = beat_row(c, t, b);
        r.fixed = 1'b1;
        r.rpt = rpt;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
        plan_row_t r;
        r = '{default: '0};
        r.wr = 1'b1;
        r.idx = i;
        r.data = d;
        return r;
    endfunction

    task automatic offer_beat(logic [1:0] c, logic t, logic b, bit fixed, motor_report_t r);
        int gap;
        if (wr_open)
        begin
            cfg_wr_en <= 1'b0;
            wr_open = 1'b0;
        end
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        cmd <= c;
        top_active <= t;
        bottom_active <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        n_ticks++;
        want_rpt = controller_tick(c, t, b);
        motor_reports.push_back(fixed ? r : want_rpt);
    endtask

    task automatic drain_ticks();
        in_valid <= 1'b0;
        while (motor_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= i;
        cfg_data <= d;
        wr_open = 1'b1;
        @(posedge clk);
        case (i)
            REG_DEBOUNCE:      cfg_now.debounce = d[7:0];
            REG_DEAD_TIME:     cfg_now.dead_time = d[9:0];
            REG_CLOSED_TO_EXT: cfg_now.closed_to_ext = d;
            REG_EXT_TO_CLOSED: cfg_now.ext_to_closed = d;
            REG_ALMOST_TO_OPN: cfg_now.almost_to_open = d;
            REG_OPN_TO_ALMOST: cfg_now.open_to_almost = d;
            REG_ALMOST_TO_EXT: cfg_now.almost_to_ext = d;
            default:           cfg_now.ext_to_almost = d;
        endcase
    endtask

    task automatic random_tick();
        int         k;
        logic [1:0] c;
        logic       b;
        k = $urandom_range(0, 99);
        if (k < 78)
            c = CMD_NONE;
        else if (k < 86)
            c = CMD_OPEN;
        else if (k < 94)
            c = CMD_CLOSE;
        else
            c = CMD_STOP;
        if ($urandom_range(0, 99) < 6)
            sens_top = ~sens_top;
        if ($urandom_range(0, 99) < 8)
            sens_bot = ~sens_bot;
        b = sens_bot;
        // short bounce on the bottom sensor
        if ($urandom_range(0, 99) < 8)
            b = ~b;
        offer_beat(c, sens_top, b, 1'b0, '0);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_seen++;
            pos_mask[position] = 1'b1;
            mode_mask[motor_mode] = 1'b1;
            if (motor_reports.size() == 0)
            begin
                $error("result beat with nothing pending");
                n_fail++;
            end
            else
            begin
                want_rpt = motor_reports.pop_front();
                check_field("drive_up", want_rpt.up, drive_up);
                check_field("drive_down", want_rpt.down, drive_down);
                check_field("drive_fast", want_rpt.fast, drive_fast);
                check_field("enable_n", want_rpt.en_n, enable_n);
                check_field("position", want_rpt.pos, position);
                check_field("motor_mode", want_rpt.mode, motor_mode);
                check_field("homed", want_rpt.homed, homed);
            end
        end
    end

    // receiver back-pressure, with one long hold-off while beats are offered
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            rx_beats <= rx_beats + 1;
        stall_phase <= stall_phase + 8'd1;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!held && rx_beats >= 400 && in_valid)
        begin
            hold_left <= 120;
            held <= 1'b1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_phase[5:0] == 6'd0)
                stall_style <= $urandom_range(0, 3);
            case (stall_style)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                2:       out_stall <= (stall_phase[2:0] >= 3'd5);
                default: out_stall <= ($urandom_range(0, 9) > 2);
            endcase
        end
    end

    initial
    begin
        #(300_000 * 12);
        $display("tb_blind_position_motor_controller failed");
        $finish;
    end

    initial
    begin
        int                    ph;
        int                    k;
        logic [CFG_DATA_W-1:0] val;

        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_NONE;
        top_active = 1'b0;
        bottom_active = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_DEBOUNCE;
        cfg_data = '0;

        cfg_now.debounce = 8'd10;
        cfg_now.dead_time = 10'd100;
        cfg_now.closed_to_ext = 16'd3000;
        cfg_now.ext_to_closed = 16'd3100;
        cfg_now.almost_to_open = 16'd4000;
        cfg_now.open_to_almost = 16'd1000;
        cfg_now.almost_to_ext = 16'd10000;
        cfg_now.ext_to_almost = 16'd4500;
        primed = 1'b0;
        bot_lvl = 1'b0;
        bot_seen = 1'b0;
        bot_hold = 8'd0;
        bot_rdy = 1'b1;
        mode_cur = M_OFF;
        run_cnt = 16'd0;
        run_on = 1'b0;
        dead_cnt = 10'd0;
        dead_on = 1'b0;
        pos_cur = P_UNKNOWN;
        pos_want = P_UNKNOWN;
        homed_f = 1'b0;
        pins = PINS_OFF;

        // open before homing is ignored; homing starts downward from the middle
        plan.push_back(known_row(CMD_OPEN, 1'b0, 1'b0,
                                 {4'b0001, P_MIDDLE, M_DOWN_SLOW, 1'b0}));
        plan.push_back(beat_row(CMD_NONE, 1'b1, 1'b1));
        // stop while homing ends homing at closed
        plan.push_back(known_row(CMD_STOP, 1'b1, 1'b1,
                                 {4'b0001, P_CLOSED, M_OFF, 1'b1}));
        // close while already closed
        plan.push_back(known_row(CMD_CLOSE, 1'b0, 1'b0,
                                 {4'b0001, P_CLOSED, M_OFF, 1'b1}));
        plan.push_back(reg_row(REG_DEBOUNCE, 16'd0));
        plan.push_back(reg_row(REG_DEAD_TIME, 16'd0));
        plan.push_back(reg_row(REG_CLOSED_TO_EXT, 16'd3));
        plan.push_back(reg_row(REG_EXT_TO_CLOSED, 16'd2));
        plan.push_back(reg_row(REG_ALMOST_TO_OPN, 16'd2));
        plan.push_back(reg_row(REG_OPN_TO_ALMOST, 16'd0));
        plan.push_back(reg_row(REG_ALMOST_TO_EXT, 16'd3));
        plan.push_back(reg_row(REG_EXT_TO_ALMOST, 16'd2));
        plan.push_back(beat_row(CMD_OPEN, 1'b0, 1'b0));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b0));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b0));
        plan.push_back(beat_row(CMD_OPEN, 1'b0, 1'b1));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b1));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b0));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b0));
        plan.push_back(beat_row(CMD_NONE, 1'b1, 1'b0));
        plan.push_back(beat_row(CMD_OPEN, 1'b1, 1'b0));
        plan.push_back(beat_row(CMD_CLOSE, 1'b1, 1'b0));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b0));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b1));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b1));
        plan.push_back(beat_row(CMD_STOP, 1'b0, 1'b1));
        plan.push_back(beat_row(CMD_CLOSE, 1'b0, 1'b0));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b0));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b0));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b0));
        plan.push_back(beat_row(CMD_OPEN, 1'b0, 1'b1));
        plan.push_back(beat_row(CMD_NONE, 1'b0, 1'b0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].wr)
            begin
                drain_ticks();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                offer_beat(plan[i].c, plan[i].t, plan[i].b, plan[i].fixed, plan[i].rpt);
        end

        // settings 2 and 5 are the all-ones and all-zeros extremes
        for (ph = 0; ph < 8; ph++)
        begin
            drain_ticks();
            for (k = 0; k < 8; k++)
            begin
                if (ph == 2)
                    val = 16'hFFFF;
                else if (ph == 5)
                    val = 16'h0000;
                else
                begin
                    val = CFG_DATA_W'($urandom);
                    if (k == REG_DEBOUNCE)
                        val[7:0] = 8'($urandom_range(0, 3));
                    else if (k == REG_DEAD_TIME)
                        val[9:0] = 10'($urandom_range(0, 4));
                    else if ($urandom_range(0, 5) == 0)
                        val = 16'd0;
                    else
                        val = CFG_DATA_W'($urandom_range(1, 30));
                end
                write_reg(k[CFG_IDX_W-1:0], val);
            end
            repeat (106) random_tick();
        end

        drain_ticks();
        repeat (10) @(posedge clk);
        $display("%0d ticks over 10 register settings, %0d result beats compared",
                 n_ticks, n_seen);
        $display("positions reached %b, motor modes reached %b", pos_mask[5:0],
                 mode_mask[4:0]);
        if (n_fail == 0)
            $display("tb_blind_position_motor_controller passed");
        else
            $display("tb_blind_position_motor_controller failed");
        $finish;
    end

endmodule
